>>> design/dnsap_pkg.sv
// Package for the DNS A-record response parser.
// Holds the parse phase type, status codes, header offsets and stage structs.
// No dependencies; imported by every design module.
`default_nettype none

package dnsap_pkg;

   // Parse phases of one message
   typedef enum logic [3:0] {
      PH_HEADER,
      PH_QNAME,
      PH_QPTR,
      PH_QTAIL,
      PH_ANAME,
      PH_APTR,
      PH_ATAIL,
      PH_ASKIP,
      PH_ADDR,
      PH_DONE,
      PH_FAIL
   } phase_type;

   // Result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_OTHER  = 2'd1;
   localparam logic [1:0] ST_WRONG  = 2'd2;
   localparam logic [1:0] ST_SERVER = 2'd3;

   // Header byte offsets that carry a check or a count
   localparam logic [3:0] HDR_ID_LO    = 4'd1;
   localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
   localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
   localparam logic [3:0] HDR_QD_LO    = 4'd5;
   localparam logic [3:0] HDR_AN_LO    = 4'd7;
   localparam logic [3:0] HDR_LAST     = 4'd11;

   // Name and record layout
   localparam logic [7:0]  PTR_MARK     = 8'hc0;
   localparam logic [7:0]  LABEL_RSVD   = 8'h40;
   localparam logic [3:0]  QTAIL_LEN    = 4'd4;
   localparam logic [3:0]  ATAIL_LEN    = 4'd10;
   localparam logic [3:0]  ATAIL_TYPE_END = 4'd2;
   localparam logic [3:0]  ATAIL_RDLEN  = 4'd8;
   localparam logic [3:0]  ADDR_LEN     = 4'd4;
   localparam logic [15:0] TYPE_A       = 16'd1;

   // One registered message byte
   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       last_byte;
   } byte_item_type;

   // One parse result
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] ipv4_address;
   } result_type;

endpackage

`default_nettype wire

>>> design/dnsap_req_if.sv
// Input channel interface: one message byte per transfer.
// Used by the top level and the input stage; no dependencies.
`default_nettype none

interface dnsap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pkt_byte;
   logic       last_byte;

   modport source (output valid, output pkt_byte, output last_byte, input ready);
   modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> design/dnsap_rsp_if.sv
// Result channel interface: status and captured IPv4 address per transfer.
// Used by the top level and the result register; no dependencies.
`default_nettype none

interface dnsap_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] ipv4_address;

   modport source (output valid, output status, output ipv4_address, input ready);
   modport sink   (input valid, input status, input ipv4_address, output ready);
endinterface

`default_nettype wire

>>> design/dns_a_response_parser_unit.sv
// Top level of the DNS A-record response parser.
// Depends on dnsap_pkg, dnsap_req_if, dnsap_rsp_if, dnsap_in_stage, dnsap_parser,
// dnsap_rsp_reg.
`default_nettype none

// Takes a DNS response one byte per transfer on req_chan and gives one result
// on rsp_chan for each byte marked last: status (ok, other response, wrong
// packet, server error) and the address of the first type A answer, zero
// unless ok. Throughput is one byte per clock unless a final byte stalls;
// bytes pass an input register and the parse logic, and the result register
// loads a result as its final byte leaves the input register. It holds one
// result; while it waits, non-final bytes of the next message keep flowing,
// and only a final byte stalls until the result is taken. The user must write
// expected_id through csr_wr_en/csr_wr_data only while no message is in flight;
// the block does not enforce this. No clearing pass is needed after reset.
module dns_a_response_parser_unit
   import dnsap_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   dnsap_req_if.sink        req_chan,
   dnsap_rsp_if.source      rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic          item_valid;
   byte_item_type item;
   logic          take;
   logic          out_free;
   logic          res_valid;
   result_type    res;

   dnsap_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dnsap_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .take        (take),
      .res_valid   (res_valid),
      .res         (res)
   );

   dnsap_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

>>> design/dnsap_in_stage.sv
// Input register stage: holds one accepted byte until the parser takes it.
// Depends on dnsap_pkg and dnsap_req_if.
`default_nettype none

module dnsap_in_stage
   import dnsap_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   dnsap_req_if.sink    req_chan,
   input  wire logic    take,
   output logic         item_valid,
   output byte_item_type item
);

   logic          valid_ff, valid_in;
   byte_item_type item_ff, item_in;
   logic          accept;

   // Free when empty or when the parser takes the held byte this cycle
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.pkt_byte  = req_chan.pkt_byte;
         item_in.last_byte = req_chan.last_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> design/dnsap_parser.sv
// Byte-wide DNS response parser: header checks, question skip, answer walk.
// Holds all parse state and the expected id register. Depends on dnsap_pkg.
`default_nettype none

module dnsap_parser
   import dnsap_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [15:0]   csr_wr_data,
   input  wire logic          item_valid,
   input  wire byte_item_type item,
   input  wire logic          out_free,
   output logic               take,
   output logic               res_valid,
   output result_type         res
);

   logic [15:0] expected_id_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_index_ff, header_index_in;
   logic [15:0] header_word_ff, header_word_in;
   logic [15:0] qd_remaining_ff, qd_remaining_in;
   logic [15:0] an_remaining_ff, an_remaining_in;
   logic [15:0] skip_count_ff, skip_count_in;
   logic [3:0]  field_index_ff, field_index_in;
   logic [15:0] record_type_ff, record_type_in;
   logic [15:0] rdata_length_ff, rdata_length_in;
   logic [31:0] found_address_ff, found_address_in;
   logic [1:0]  held_status_ff, held_status_in;
   logic        answer_found_ff, answer_found_in;

   logic [7:0]  b;
   logic [15:0] hw;
   logic [3:0]  fi_inc;
   logic [15:0] rt_new, rl_new;
   logic [15:0] an_dec, qd_dec, skip_dec;
   logic        name_ptr_q;

   // A final byte needs room in the result register
   assign take = item_valid && (!item.last_byte || out_free);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
      end else if (csr_wr_en) begin
         expected_id_ff <= csr_wr_data;
      end
   end

   // Next state for one byte
   always_comb begin
      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      header_word_in   = header_word_ff;
      qd_remaining_in  = qd_remaining_ff;
      an_remaining_in  = an_remaining_ff;
      skip_count_in    = skip_count_ff;
      field_index_in   = field_index_ff;
      record_type_in   = record_type_ff;
      rdata_length_in  = rdata_length_ff;
      found_address_in = found_address_ff;
      held_status_in   = held_status_ff;
      answer_found_in  = answer_found_ff;

      b          = item.pkt_byte;
      hw         = {header_word_ff[7:0], b};
      fi_inc     = field_index_ff + 4'd1;
      rt_new     = (field_index_ff < ATAIL_TYPE_END) ? {record_type_ff[7:0], b}
                                                     : record_type_ff;
      rl_new     = (field_index_ff >= ATAIL_RDLEN) ? {rdata_length_ff[7:0], b}
                                                  : rdata_length_ff;
      an_dec     = an_remaining_ff - 16'd1;
      qd_dec     = qd_remaining_ff - 16'd1;
      skip_dec   = skip_count_ff - 16'd1;
      name_ptr_q = (phase_ff == PH_QNAME);

      case (phase_ff)
         PH_HEADER: begin
            header_word_in = hw;
            if (header_index_ff == HDR_ID_LO && hw != expected_id_ff) begin
               held_status_in = ST_OTHER;
               phase_in       = PH_FAIL;
            end else if (header_index_ff == HDR_FLAGS_HI && !b[7]) begin
               held_status_in = ST_WRONG;
               phase_in       = PH_FAIL;
            end else if (header_index_ff == HDR_FLAGS_LO && b[3:0] != 4'd0) begin
               held_status_in = ST_SERVER;
               phase_in       = PH_FAIL;
            end else if (header_index_ff == HDR_AN_LO && hw == 16'd0) begin
               an_remaining_in = hw;
               held_status_in  = ST_SERVER;
               phase_in        = PH_FAIL;
            end else begin
               if (header_index_ff == HDR_QD_LO) qd_remaining_in = hw;
               if (header_index_ff == HDR_AN_LO) an_remaining_in = hw;
               if (header_index_ff == HDR_LAST) begin
                  header_index_in = 4'd0;
                  skip_count_in   = '0;
                  phase_in        = (qd_remaining_ff != 16'd0) ? PH_QNAME : PH_ANAME;
               end else begin
                  header_index_in = header_index_ff + 4'd1;
               end
            end
         end
         // Label bytes are skipped by count; zero ends, pointer mark ends after one more
         PH_QNAME, PH_ANAME: begin
            if (skip_count_ff != 16'd0) begin
               skip_count_in = skip_dec;
            end else if (b == 8'd0) begin
               field_index_in = 4'd0;
               phase_in       = name_ptr_q ? PH_QTAIL : PH_ATAIL;
            end else if (b >= PTR_MARK) begin
               phase_in = name_ptr_q ? PH_QPTR : PH_APTR;
            end else if (b >= LABEL_RSVD) begin
               held_status_in = ST_WRONG;
               phase_in       = PH_FAIL;
            end else begin
               skip_count_in = {8'd0, b};
            end
         end
         PH_QPTR: begin
            field_index_in = 4'd0;
            phase_in       = PH_QTAIL;
         end
         PH_APTR: begin
            field_index_in = 4'd0;
            phase_in       = PH_ATAIL;
         end
         PH_QTAIL: begin
            if (fi_inc == QTAIL_LEN) begin
               field_index_in  = 4'd0;
               qd_remaining_in = qd_dec;
               phase_in        = (qd_dec != 16'd0) ? PH_QNAME : PH_ANAME;
            end else begin
               field_index_in = fi_inc;
            end
         end
         // Fixed record part: type in the first two bytes, RDLENGTH in the last two
         PH_ATAIL: begin
            if (fi_inc == ATAIL_LEN) begin
               field_index_in  = 4'd0;
               record_type_in  = '0;
               rdata_length_in = '0;
               if (rt_new == TYPE_A) begin
                  found_address_in = '0;
                  phase_in         = PH_ADDR;
               end else if (rl_new == 16'd0) begin
                  an_remaining_in = an_dec;
                  if (an_dec == 16'd0) begin
                     held_status_in = ST_WRONG;
                     phase_in       = PH_FAIL;
                  end else begin
                     phase_in = PH_ANAME;
                  end
               end else begin
                  skip_count_in = rl_new;
                  phase_in      = PH_ASKIP;
               end
            end else begin
               field_index_in  = fi_inc;
               record_type_in  = rt_new;
               rdata_length_in = rl_new;
            end
         end
         PH_ASKIP: begin
            skip_count_in = skip_dec;
            if (skip_dec == 16'd0) begin
               an_remaining_in = an_dec;
               if (an_dec == 16'd0) begin
                  held_status_in = ST_WRONG;
                  phase_in       = PH_FAIL;
               end else begin
                  phase_in = PH_ANAME;
               end
            end
         end
         PH_ADDR: begin
            found_address_in = {found_address_ff[23:0], b};
            if (fi_inc == ADDR_LEN) begin
               field_index_in  = 4'd0;
               answer_found_in = 1'b1;
               phase_in        = PH_DONE;
            end else begin
               field_index_in = fi_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // Result on the final byte
   always_comb begin
      res_valid = take && item.last_byte;
      if (phase_in == PH_DONE && answer_found_in) begin
         res.status       = ST_OK;
         res.ipv4_address = found_address_in;
      end else if (phase_in == PH_FAIL) begin
         res.status       = held_status_in;
         res.ipv4_address = '0;
      end else begin
         res.status       = ST_WRONG;
         res.ipv4_address = '0;
      end
   end

   // Parse state; the final byte restarts the parse
   always_ff @(posedge clock) begin
      if (reset || (take && item.last_byte)) begin
         phase_ff         <= PH_HEADER;
         header_index_ff  <= '0;
         header_word_ff   <= '0;
         qd_remaining_ff  <= '0;
         an_remaining_ff  <= '0;
         skip_count_ff    <= '0;
         field_index_ff   <= '0;
         record_type_ff   <= '0;
         rdata_length_ff  <= '0;
         found_address_ff <= '0;
         held_status_ff   <= '0;
         answer_found_ff  <= 1'b0;
      end else if (take) begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         header_word_ff   <= header_word_in;
         qd_remaining_ff  <= qd_remaining_in;
         an_remaining_ff  <= an_remaining_in;
         skip_count_ff    <= skip_count_in;
         field_index_ff   <= field_index_in;
         record_type_ff   <= record_type_in;
         rdata_length_ff  <= rdata_length_in;
         found_address_ff <= found_address_in;
         held_status_ff   <= held_status_in;
         answer_found_ff  <= answer_found_in;
      end
   end

`ifndef SYNTH
   // Every final byte returns the parser to the header
   a_restart: assert property (@(posedge clock) disable iff (reset)
      take && item.last_byte |=> phase_ff == PH_HEADER && header_index_ff == 4'd0)
      else $error("parser did not restart after final byte");

   // A captured address always comes with the found flag
   a_done_found: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> answer_found_ff)
      else $error("done phase without captured address");

   // A failed message always holds a failing status
   a_fail_status: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FAIL |-> held_status_ff != ST_OK)
      else $error("fail phase holds ok status");
`endif

endmodule

`default_nettype wire

>>> design/dnsap_rsp_reg.sv
// Result register: holds one parse result until the sink takes it.
// Depends on dnsap_pkg and dnsap_rsp_if.
`default_nettype none

module dnsap_rsp_reg
   import dnsap_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_valid,
   input  wire result_type res,
   output logic            out_free,
   dnsap_rsp_if.source     rsp_chan
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.status       = res_ff.status;
   assign rsp_chan.ipv4_address = res_ff.ipv4_address;

`ifndef SYNTH
   // Only an ok result carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && res_ff.status != ST_OK |-> res_ff.ipv4_address == 32'd0)
      else $error("address present on failing result");

   // A new result is only loaded when the register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result loaded over a pending result");
`endif

endmodule

`default_nettype wire
